// ----- rtl/sss_pkg.sv -----
`timescale 1ns / 1ps

package sss_pkg;

	// Character codes the splitter reacts to.
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_HASH      = 8'h23;
	localparam logic [7:0] CH_DOLLAR    = 8'h24;
	localparam logic [7:0] CH_LPAREN    = 8'h28;
	localparam logic [7:0] CH_RPAREN    = 8'h29;
	localparam logic [7:0] CH_SEMICOLON = 8'h3B;
	localparam logic [7:0] CH_LT        = 8'h3C;
	localparam logic [7:0] CH_GT        = 8'h3E;
	localparam logic [7:0] CH_LBRACKET  = 8'h5B;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_RBRACKET  = 8'h5D;
	localparam logic [7:0] CH_LOWER_I   = 8'h69;
	localparam logic [7:0] CH_LOWER_N   = 8'h6E;
	localparam logic [7:0] CH_LOWER_R   = 8'h72;
	localparam logic [7:0] CH_LOWER_T   = 8'h74;
	localparam logic [7:0] CH_LOWER_U   = 8'h75;
	localparam logic [7:0] CH_LBRACE    = 8'h7B;
	localparam logic [7:0] CH_RBRACE    = 8'h7D;

	localparam logic signed [7:0] DEPTH_MAX = 8'sd127;
	localparam logic signed [7:0] DEPTH_MIN = -8'sd128;

	// Prefix matcher for "<run" and "<init".
	typedef enum logic [3:0] {
		TAG_LEAD  = 4'd0,
		TAG_LT    = 4'd1,
		TAG_R     = 4'd2,
		TAG_RU    = 4'd3,
		TAG_I     = 4'd4,
		TAG_IN    = 4'd5,
		TAG_INI   = 4'd6,
		TAG_MATCH = 4'd7,
		TAG_FAIL  = 4'd8
	} tag_state_t;

	// One result beat.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_present;
		logic       statement_end;
		logic       last_of_run;
	} result_t;

	function automatic tag_state_t tag_next(tag_state_t st, logic [7:0] b, logic skip);
		tag_state_t nx;
		nx = TAG_FAIL;
		case (st)
			TAG_LEAD: begin
				if (b == CH_SPACE && skip) nx = TAG_LEAD;
				else if (b == CH_LT) nx = TAG_LT;
			end
			TAG_LT: begin
				if (b == CH_LOWER_R) nx = TAG_R;
				else if (b == CH_LOWER_I) nx = TAG_I;
			end
			TAG_R:     if (b == CH_LOWER_U) nx = TAG_RU;
			TAG_RU:    if (b == CH_LOWER_N) nx = TAG_MATCH;
			TAG_I:     if (b == CH_LOWER_N) nx = TAG_IN;
			TAG_IN:    if (b == CH_LOWER_I) nx = TAG_INI;
			TAG_INI:   if (b == CH_LOWER_T) nx = TAG_MATCH;
			TAG_MATCH: nx = TAG_MATCH;
			default:   nx = TAG_FAIL;
		endcase
		return nx;
	endfunction

endpackage

// ----- rtl/script_statement_splitter.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Handshake               Payload
// s_axis    in   s_axis_tvalid/tready    tdata[7:0] in_byte
// m_axis    out  m_axis_tvalid/tready    tdata[7:0] out_byte, tuser[0] byte_present,
//                                        tuser[1] statement_end, tlast last_of_run
// cfg       in   cfg_wr_en (no wait)     cfg_wr_data skip_leading_spaces
//
// Each input beat is held in an input register and processed from it once the result
// buffer has room, by one level of flag, depth and prefix logic, which writes zero,
// one or two result beats into a two-entry result buffer. One input beat per cycle
// is sustained while m_axis does not stall and each beat yields at most one result;
// a beat yielding two (an opening round bracket with its inserted space) holds up the next.
// arst_n clears every mode flag, the depth, the prefix matcher and both buffers, and
// sets file mode. A stall on m_axis holds the result buffer and then the input
// register, and s_axis_tready drops once both are full.

module script_statement_splitter
	import sss_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] in_byte
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] out_byte
	output logic [1:0] m_axis_tuser,  // [0] byte_present, [1] statement_end
	output logic       m_axis_tlast,  // last_of_run
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data    // skip_leading_spaces
);

	// Input register.
	logic       in_valid_s1;
	logic [7:0] in_byte_s1;

	// Splitter state.
	logic              skip_q;
	logic              comment_q, quote_q, special_q, nonempty_q;
	logic signed [7:0] depth_q;
	logic [7:0]        prev_q;
	tag_state_t        tag_q;

	logic              comment_n, quote_n, special_n, nonempty_n;
	logic signed [7:0] depth_n;
	logic [7:0]        prev_n;
	tag_state_t        tag_n, tag_space;

	// Result buffer: entry 0 is the head shown on m_axis.
	result_t    res_q [2];
	logic [1:0] out_cnt_q;

	result_t    r0, r1;
	logic [1:0] n_res;
	logic       pop, load_ok, proc;

	// Single-append decode.
	logic       do_push, push_end, pre_space, after_bs;
	logic [7:0] c;

	assign c        = in_byte_s1;
	assign after_bs = nonempty_q && (prev_q == CH_BACKSLASH);

	assign pop           = m_axis_tvalid && m_axis_tready;
	assign load_ok       = (out_cnt_q == 2'd0) || (out_cnt_q == 2'd1 && pop);
	assign proc          = in_valid_s1 && load_ok;
	assign s_axis_tready = !in_valid_s1 || proc;

	assign m_axis_tvalid   = (out_cnt_q != 2'd0);
	assign m_axis_tdata    = res_q[0].out_byte;
	assign m_axis_tuser[0] = res_q[0].byte_present;
	assign m_axis_tuser[1] = res_q[0].statement_end;
	assign m_axis_tlast    = res_q[0].last_of_run;

	// Classify the byte and decide which flags change and whether it is appended.
	always_comb begin
		comment_n = comment_q;
		quote_n   = quote_q;
		special_n = special_q;
		depth_n   = depth_q;
		do_push   = 1'b0;
		push_end  = 1'b0;
		pre_space = 1'b0;

		if (c == CH_NEWLINE) begin
			comment_n = 1'b0;
			if (special_q) special_n = 1'b0;
		end else if (!comment_q) begin
			do_push = 1'b1;
			case (c)
				CH_HASH: begin
					if (!after_bs) begin
						comment_n = 1'b1;
						do_push   = 1'b0;
					end
				end
				CH_DOLLAR: begin
					if (!quote_q) special_n = 1'b1;
				end
				CH_QUOTE: begin
					if (!after_bs) quote_n = !quote_q;
				end
				CH_GT: begin
					push_end = (tag_q == TAG_MATCH);
				end
				CH_LPAREN, CH_LBRACKET: begin
					pre_space = (c == CH_LPAREN) && !quote_q && !special_q;
					if (depth_q != DEPTH_MAX) depth_n = depth_q + 8'sd1;
				end
				CH_RPAREN, CH_RBRACKET: begin
					if (depth_q != DEPTH_MIN) depth_n = depth_q - 8'sd1;
				end
				CH_SEMICOLON, CH_LBRACE, CH_RBRACE: begin
					push_end = !quote_q && !special_q && (depth_q <= 8'sd0);
				end
				default: ;
			endcase
		end
	end

	// Build the result beats and the statement-level state that follows them.
	always_comb begin
		r0         = '0;
		r1         = '0;
		n_res      = 2'd0;
		prev_n     = prev_q;
		nonempty_n = nonempty_q;
		tag_n      = tag_q;
		tag_space  = tag_next(tag_q, CH_SPACE, skip_q);

		if (c == CH_NEWLINE && special_q) begin
			// A newline closing a special command gives a bare statement end.
			r0.statement_end = 1'b1;
			r0.last_of_run   = 1'b1;
			n_res            = 2'd1;
		end else if (do_push && pre_space) begin
			r0.out_byte     = CH_SPACE;
			r0.byte_present = 1'b1;
			r1.out_byte     = c;
			r1.byte_present = 1'b1;
			r1.last_of_run  = 1'b1;
			n_res           = 2'd2;
			tag_n           = tag_next(tag_space, c, skip_q);
			prev_n          = c;
			nonempty_n      = 1'b1;
		end else if (do_push) begin
			r0.out_byte      = c;
			r0.byte_present  = 1'b1;
			r0.statement_end = push_end;
			r0.last_of_run   = 1'b1;
			n_res            = 2'd1;
			if (!push_end) begin
				tag_n      = tag_next(tag_q, c, skip_q);
				prev_n     = c;
				nonempty_n = 1'b1;
			end
		end
	end

	logic closes;
	assign closes = (c == CH_NEWLINE && special_q) || (do_push && push_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			skip_q      <= 1'b1;
			comment_q   <= 1'b0;
			quote_q     <= 1'b0;
			special_q   <= 1'b0;
			nonempty_q  <= 1'b0;
			depth_q     <= '0;
			prev_q      <= '0;
			tag_q       <= TAG_LEAD;
			out_cnt_q   <= 2'd0;
		end else begin
			if (cfg_wr_en) skip_q <= cfg_wr_data;

			if (s_axis_tready) in_valid_s1 <= s_axis_tvalid;

			if (proc) begin
				comment_q <= comment_n;
				quote_q   <= quote_n;
				special_q <= special_n;
				if (closes) begin
					// End of statement: quote and special-command modes carry over.
					depth_q    <= '0;
					prev_q     <= '0;
					nonempty_q <= 1'b0;
					tag_q      <= TAG_LEAD;
				end else begin
					depth_q    <= depth_n;
					prev_q     <= prev_n;
					nonempty_q <= nonempty_n;
					tag_q      <= tag_n;
				end
				out_cnt_q <= n_res;
			end else if (pop) begin
				out_cnt_q <= out_cnt_q - 2'd1;
			end
		end
	end

	// Payload registers need no reset.
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) in_byte_s1 <= s_axis_tdata;
		if (proc) begin
			res_q[0] <= r0;
			res_q[1] <= r1;
		end else if (pop && out_cnt_q == 2'd2) begin
			res_q[0] <= res_q[1];
		end
	end

	// A bare result is always a statement end that finishes its run.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tuser[1] && m_axis_tlast)
		else $error("bare result without statement end or run end");

	// With two results buffered, only the second ends the run.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_cnt_q == 2'd2 |-> !res_q[0].last_of_run && res_q[1].last_of_run)
		else $error("run end misplaced in result buffer");

	// Closing a statement resets the depth and the prefix matcher.
	assert property (@(posedge clk) disable iff (!arst_n)
		proc && closes |=> depth_q == 8'sd0 && tag_q == TAG_LEAD && !nonempty_q)
		else $error("statement state not cleared at statement end");

	// The result buffer never overflows.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_cnt_q != 2'd3)
		else $error("result buffer overflow");

endmodule
